// ----- rtl/vn_pkg.sv -----
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;
    localparam int unsigned COMP_W  = 32;            // input and output component width
    localparam int unsigned SQ_W    = 64;            // square of a magnitude
    localparam int unsigned SUM_W   = 64;            // sum of three squares
    localparam int unsigned REM_W   = 123;           // remainder c^2 * 2^60 - q^2 * S
    localparam int unsigned PROD_W  = 94;            // running q * S
    localparam int unsigned Q_W     = 31;            // result magnitude, up to 2^30
    localparam int unsigned DELTA_W = 126;           // trial step before compare
    localparam int unsigned NUM_BITS = 31;           // result bits, one per cell
    localparam int unsigned REM_SHIFT = 60;
    localparam logic [COMP_W-1:0] ONE_Q30 = 32'h4000_0000;

    // Per-component state carried down the cell chain
    typedef struct packed {
        logic [REM_W-1:0]  e;
        logic [PROD_W-1:0] p;
        logic [Q_W-1:0]    q;
        logic              neg;
    } lane_t;

    // One item as it moves from cell to cell
    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [SUM_W-1:0] s;
        lane_t [2:0]      lane;
    } cell_t;
endpackage

// ----- rtl/vn_front.sv -----
// Front end: magnitudes, squares, sum of squares and chain seed.
`timescale 1ns / 1ps
module vn_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [3*vn_pkg::COMP_W-1:0]          in_data,
    output vn_pkg::cell_t                        out_cell
);
    import vn_pkg::*;

    logic                 a_vld_reg;
    logic [SQ_W-1:0]      a_sq_reg  [3];
    logic [2:0]           a_neg_reg;
    logic [COMP_W-1:0]    mag       [3];
    logic [2:0]           neg;
    cell_t                b_next;
    cell_t                b_reg;
    logic [SUM_W-1:0]     sum;

    // Take magnitudes; the most negative word keeps its full 2^31
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i] = in_data[i*COMP_W + COMP_W - 1];
            mag[i] = neg[i] ? (~in_data[i*COMP_W +: COMP_W] + 32'd1)
                            : in_data[i*COMP_W +: COMP_W];
        end
    end

    // Stage A: square each magnitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_sq_reg[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
            end
            a_neg_reg <= neg;
        end
    end

    // Stage B: sum squares and seed the remainders
    always_comb begin
        sum = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        b_next.vld  = a_vld_reg;
        b_next.zero = (sum == '0);
        b_next.s    = sum;
        for (int i = 0; i < 3; i++) begin
            b_next.lane[i].e   = REM_W'(a_sq_reg[i]) << REM_SHIFT;
            b_next.lane[i].p   = '0;
            b_next.lane[i].q   = '0;
            b_next.lane[i].neg = a_neg_reg[i];
        end
    end

    // Hold the seed; only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.vld <= 1'b0;
        end else if (en) begin
            b_reg.vld <= b_next.vld;
        end
        if (en) begin
            b_reg.zero <= b_next.zero;
            b_reg.s    <= b_next.s;
            b_reg.lane <= b_next.lane;
        end
    end

    assign out_cell = b_reg;
endmodule

// ----- rtl/vn_cell.sv -----
// One result bit: trial-set bit BIT of q in all three lanes.
`timescale 1ns / 1ps
module vn_cell #(
    parameter int unsigned BIT = 30
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  vn_pkg::cell_t  in_cell,
    output vn_pkg::cell_t  out_cell
);
    import vn_pkg::*;

    cell_t                out_next;
    cell_t                out_reg;
    logic [DELTA_W-1:0]   delta [3];
    logic [2:0]           take;

    // (q + 2^b)^2 S - q^2 S = (qS << b+1) + (S << 2b); keep the bit if it fits
    always_comb begin
        out_next = in_cell;
        for (int i = 0; i < 3; i++) begin
            delta[i] = (DELTA_W'(in_cell.lane[i].p) << (BIT + 1))
                     + (DELTA_W'(in_cell.s) << (2 * BIT));
            take[i]  = (delta[i] <= DELTA_W'(in_cell.lane[i].e));
            if (take[i]) begin
                out_next.lane[i].e = in_cell.lane[i].e - delta[i][REM_W-1:0];
                out_next.lane[i].p = in_cell.lane[i].p + (PROD_W'(in_cell.s) << BIT);
                out_next.lane[i].q = in_cell.lane[i].q | (Q_W'(1) << BIT);
            end
        end
    end

    // Advance the item; only the valid bit is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else if (en) begin
            out_reg.vld <= out_next.vld;
        end
        if (en) begin
            out_reg.zero <= out_next.zero;
            out_reg.s    <= out_next.s;
            out_reg.lane <= out_next.lane;
        end
    end

    assign out_cell = out_reg;
endmodule

// ----- rtl/vector3_normalize.sv -----
// Top level of the three-component vector normalizer.
// Usage:
//   s_ channel takes one vector (x, y, z signed 32-bit, same scale) per item.
//   m_ channel returns the unit vector as signed Q1.30, rounded toward zero,
//   and m_tuser flags an all-zero input, which returns (0, 0, 1.0).
// Pipeline: 2 front-end stages, 31 bit cells and 1 output register
//   lie between s_ accept and m_tvalid.
// Throughput: one item per cycle while the receiver does not stall; every
//   stage is a register, and each bit cell does one shift, add and compare per lane.
// Stall: the whole pipeline advances only while the output register is
//   empty or being taken; s_tready follows that, so a stalled receiver
//   holds every item in place and none is lost.
// Reset: aresetn low clears all valid bits; the pipeline comes up empty.
`timescale 1ns / 1ps
module vector3_normalize (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // unit_x [31:0], unit_y [63:32], unit_z [95:64]
    output logic         m_tuser    // was_zero [0]
);
    import vn_pkg::*;

    logic                  en;
    cell_t                 chain [NUM_BITS+1];
    logic                  m_tvalid_reg;
    logic [3*COMP_W-1:0]   m_tdata_reg;
    logic                  m_tuser_reg;
    logic [3*COMP_W-1:0]   m_tdata_next;

    // Advance everything when the output slot is free or being taken
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    vn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .in_data  (s_tdata),
        .out_cell (chain[0])
    );

    // Cell chain, most significant result bit first
    for (genvar g = 0; g < NUM_BITS; g++) begin : g_cell
        vn_cell #(
            .BIT (NUM_BITS - 1 - g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_cell  (chain[g]),
            .out_cell (chain[g+1])
        );
    end

    // Apply signs and the zero-vector result
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_tdata_next[i*COMP_W +: COMP_W] = chain[NUM_BITS].lane[i].neg
                ? (~{1'b0, chain[NUM_BITS].lane[i].q} + 32'd1)
                : {1'b0, chain[NUM_BITS].lane[i].q};
        end
        if (chain[NUM_BITS].zero) begin
            m_tdata_next = {ONE_Q30, {(2*COMP_W){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[NUM_BITS].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= chain[NUM_BITS].zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // Zero flag always comes with the fixed (0, 0, 1.0) result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == {ONE_Q30, {(2*COMP_W){1'b0}}})
        else $error("zero vector result wrong");

    // The x and z components never exceed unit magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(ONE_Q30)
                   && $signed(m_tdata[31:0]) >= -$signed(ONE_Q30)
                   && $signed(m_tdata[95:64]) <= $signed(ONE_Q30)
                   && $signed(m_tdata[95:64]) >= -$signed(ONE_Q30)))
        else $error("unit component out of range");

    // Pipeline comes out of reset empty
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("valid after reset");
`endif
endmodule

// ----- dv/tb_vector3_normalize.sv -----
// Self-checking testbench for the three-component vector normalizer.
`timescale 1ns / 1ps
module tb_vector3_normalize;
    import vn_pkg::*;

    localparam int unsigned LATENCY     = 34;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam longint      CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        zero;
        logic [31:0] uz;
        logic [31:0] uy;
        logic [31:0] ux;
    } unit_vec_t;

    // Directed vector with an optional typed-in result
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          known;
        unit_vec_t   res;
    } vec_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    unit_vec_t   expected_units[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          long_hold = 1'b0;

    vector3_normalize dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Largest q with q*q*s <= m*m*2^60, signed
    function automatic logic [31:0] unit_of(logic [32:0] m, bit neg, logic [63:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [30:0]  q;
        logic [30:0]  t;
        rhs = ({64'd0, m} * {64'd0, m}) << 60;
        q = '0;
        for (int b = 30; b >= 0; b--) begin
            t = q | (31'd1 << b);
            lhs = {97'd0, t} * {97'd0, t} * {64'd0, s};
            if (lhs <= rhs) q = t;
        end
        return neg ? 32'd0 - {1'b0, q} : {1'b0, q};
    endfunction

    function automatic unit_vec_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic [32:0] mx, my, mz;
        logic [63:0] s;
        unit_vec_t   r;
        mx = x[31] ? 33'd0 - {x[31], x} : {1'b0, x};
        my = y[31] ? 33'd0 - {y[31], y} : {1'b0, y};
        mz = z[31] ? 33'd0 - {z[31], z} : {1'b0, z};
        s = {31'd0, mx} * {31'd0, mx} + {31'd0, my} * {31'd0, my}
          + {31'd0, mz} * {31'd0, mz};
        if (s == 0) begin
            r.ux = '0; r.uy = '0; r.uz = ONE_Q30; r.zero = 1'b1;
        end else begin
            r.ux = unit_of(mx, x[31], s);
            r.uy = unit_of(my, y[31], s);
            r.uz = unit_of(mz, z[31], s);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item, wait for its accept, log the expected result
    task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_units.push_back(normalize(x, y, z));
    endtask

    // Cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver backpressure, with one long hold-off early on
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        while (1) begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (200) @(posedge aclk);
                long_hold = 1'b0;
            end
            stall = $urandom_range(0, 16);
            if ($urandom_range(0, 1)) stall = 0;
            m_tready <= (stall == 0);
            if (stall != 0) begin
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Compare each taken item with the oldest expectation
    always @(posedge aclk) begin
        unit_vec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected item %h zero=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = expected_units.pop_front();
                if (m_tdata[31:0] !== want.ux) begin
                    $display("%0t: unit_x exp %h got %h", $time, want.ux, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.uy) begin
                    $display("%0t: unit_y exp %h got %h", $time, want.uy, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== want.uz) begin
                    $display("%0t: unit_z exp %h got %h", $time, want.uz, m_tdata[95:64]);
                    errors++;
                end
                if (m_tuser !== want.zero) begin
                    $display("%0t: was_zero exp %b got %b", $time, want.zero, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        vec_row_t  rows[$];
        unit_vec_t got;
        // Zero vector, single axes at both extremes, full-scale and small mixes
        rows.push_back('{32'd0, 32'd0, 32'd0, 1, '{1'b1, ONE_Q30, 32'd0, 32'd0}});
        rows.push_back('{32'd5, 32'd0, 32'd0, 1, '{1'b0, 32'd0, 32'd0, ONE_Q30}});
        rows.push_back('{32'd0, -32'd7, 32'd0, 1, '{1'b0, 32'd0, -ONE_Q30, 32'd0}});
        rows.push_back('{32'd0, 32'd0, 32'h8000_0000, 1, '{1'b0, -ONE_Q30, 32'd0, 32'd0}});
        rows.push_back('{32'h8000_0000, 32'd0, 32'd0, 1, '{1'b0, 32'd0, 32'd0, -ONE_Q30}});
        rows.push_back('{32'h7fff_ffff, 32'd0, 32'd0, 1, '{1'b0, 32'd0, 32'd0, ONE_Q30}});
        rows.push_back('{32'd0, 32'h7fff_ffff, 32'd0, 1, '{1'b0, 32'd0, ONE_Q30, 32'd0}});
        rows.push_back('{32'd0, 32'd0, 32'd1, 1, '{1'b0, ONE_Q30, 32'd0, 32'd0}});
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0});
        rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, '0});
        rows.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, '0});
        rows.push_back('{32'd1, 32'd1, 32'd1, 0, '0});
        rows.push_back('{-32'd1, 32'd1, -32'd1, 0, '0});
        rows.push_back('{32'd3, 32'd4, 32'd0, 0, '0});
        rows.push_back('{32'd1, 32'h8000_0000, 32'd0, 0, '0});
        rows.push_back('{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 0, '0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; typed-in results checked against the predictor too
        foreach (rows[i]) begin
            got = normalize(rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].known && got !== rows[i].res) begin
                $display("%0t: row %0d exp %h got %h", $time, i, rows[i].res, got);
                errors++;
            end
            send_vec(rows[i].x, rows[i].y, rows[i].z);
        end

        // Random vectors; stall the output once to fill the pipeline
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) long_hold = 1'b1;
            send_vec(random_comp(), random_comp(), random_comp());
        end
        s_tvalid <= 1'b0;

        // Drain, then a quiet tail
        while (expected_units.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0 && expected_units.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
